// ===== design/lvbs_pkg.sv =====
// shared types and constants of the loudest voice budget selector
package lvbs_pkg;

  // default sizing
  localparam int unsigned LVBS_MAX_CHANNELS = 32;
  localparam int unsigned LVBS_VOLUME_BITS  = 8;

  // fixed field widths of the ports
  localparam int unsigned IN_VOLUME_W   = 8;
  localparam int unsigned OUT_CHANNEL_W = 5;
  localparam int unsigned OUT_VOLUME_W  = 8;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned CFG_COUNT_W   = 6;
  localparam int unsigned CFG_LIMIT_W   = 6;
  localparam int unsigned CFG_BUDGET_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_BUDGET = 2'd2;

  // register reset values
  localparam logic [CFG_COUNT_W-1:0]  CHANNEL_COUNT_RST = 6'd32;
  localparam logic [CFG_LIMIT_W-1:0]  MIX_LIMIT_RST     = 6'd8;
  localparam logic [CFG_BUDGET_W-1:0] VOLUME_BUDGET_RST = 8'd32;

  // input word
  typedef struct packed {
    logic                   side;
    logic [IN_VOLUME_W-1:0] volume;
  } lvbs_in_t;

  // result word
  typedef struct packed {
    logic [OUT_CHANNEL_W-1:0] channel;
    logic [OUT_VOLUME_W-1:0]  mix_volume;
    logic                     none_selected;
    logic                     last;
  } lvbs_out_t;

endpackage

// ===== design/loudest_voice_budget_selector.sv =====
// loudest voice selection under a voice limit and a volume budget
// after the last volume of a frame the average is formed in the bit serial divider;
//   then the insertion sort, the selection of voices and their emission run in turn,
//   all bound by the single order memory read port
// throughput: one volume word per cycle while loading, one frame at a time
// reset: registers to their defaults, both stored channel orders read as identity
module loudest_voice_budget_selector
  import lvbs_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = LVBS_MAX_CHANNELS,
  parameter int unsigned VOLUME_BITS  = LVBS_VOLUME_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lvbs_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lvbs_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_CHANNELS);
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned VOL_W = VOLUME_BITS;
  localparam int unsigned SUM_W = VOL_W + CNT_W;
  localparam int unsigned MW    = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
  localparam int unsigned VB    = (VOL_W > 8) ? VOL_W : 8;
  localparam int unsigned CB    = (IDX_W > OUT_CHANNEL_W) ? IDX_W : OUT_CHANNEL_W;

  typedef enum logic [4:0] {
    ST_LOAD, ST_DIV,
    ST_OUT_RD, ST_OUT_W1, ST_OUT_W2,
    ST_IN_RD, ST_IN_W1, ST_IN_W2,
    ST_SEL_RD, ST_SEL_W1, ST_SEL_W2, ST_SEL_END,
    ST_EM_RD, ST_EM_W1, ST_EM_W2, ST_EM_PUSH, ST_EM_NONE
  } state_e;

  state_e                  state_q;
  logic [CFG_COUNT_W-1:0]  cfg_count_q;
  logic [CFG_LIMIT_W-1:0]  cfg_limit_q;
  logic [CFG_BUDGET_W-1:0] cfg_budget_q;
  logic [CNT_W-1:0]        load_cnt_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    side_q;
  logic [SUM_W-1:0]        avg_q;
  logic [CNT_W-1:0]        i_q;
  logic [CNT_W-1:0]        j_q;
  logic [CNT_W-1:0]        k_q;
  logic [CNT_W-1:0]        n_q;
  logic [IDX_W-1:0]        x_q;
  logic [IDX_W-1:0]        y_q;
  logic [VOL_W-1:0]        xkey_q;
  logic [VOL_W-1:0]        total_q;
  logic [VOL_W-1:0]        last_vol_q;
  logic [VOL_W-1:0]        pend_vol_q;
  logic                    out_valid_q;
  lvbs_out_t               out_q;

  logic [MW-1:0]           cnt_ext;
  logic [MW-1:0]           cc_ext;
  logic [MW-1:0]           lim_raw;
  logic [MW-1:0]           lim_ext;
  logic [CNT_W-1:0]        cc;
  logic [CNT_W-1:0]        lim;
  logic [VB-1:0]           budget_ext;
  logic [VOL_W-1:0]        budget;
  logic [VB-1:0]           in_vol_ext;
  logic [VOL_W-1:0]        in_vol;
  logic                    in_fire;
  logic [CNT_W-1:0]        load_next;
  logic [SUM_W-1:0]        sum_next;
  logic                    frame_end;
  logic                    div_busy;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic [VOL_W-1:0]        vol_rdata;
  logic [IDX_W-1:0]        ord_rdata;
  logic                    ord_we;
  logic [IDX_W:0]          ord_waddr;
  logic [IDX_W-1:0]        ord_wdata;
  logic [IDX_W:0]          ord_raddr;
  logic [CNT_W-1:0]        jm1;
  logic [IDX_W-1:0]        key_ch;
  logic [VOL_W-1:0]        key;
  logic [VOL_W:0]          tsum;
  logic [VOL_W-1:0]        trim;
  logic [CB-1:0]           ch_ext;
  logic [VB-1:0]           pend_ext;

  // effective channel count and voice limit
  always_comb begin
    cnt_ext = MW'(cfg_count_q);
    if (cnt_ext == '0) begin
      cc_ext = MW'(1);
    end else if (cnt_ext > MW'(MAX_CHANNELS)) begin
      cc_ext = MW'(MAX_CHANNELS);
    end else begin
      cc_ext = cnt_ext;
    end
    lim_raw = MW'(cfg_limit_q);
    lim_ext = (lim_raw > cc_ext) ? cc_ext : lim_raw;
    cc      = cc_ext[CNT_W-1:0];
    lim     = lim_ext[CNT_W-1:0];
  end

  // volume width conversions
  assign budget_ext = VB'(cfg_budget_q);
  assign budget     = budget_ext[VOL_W-1:0];
  assign in_vol_ext = VB'(in_data_i.volume);
  assign in_vol     = in_vol_ext[VOL_W-1:0];
  assign ch_ext     = CB'(y_q);
  assign pend_ext   = VB'(pend_vol_q);

  // load side
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_next  = load_cnt_q + CNT_W'(1);
  assign sum_next   = sum_q + SUM_W'(in_vol);
  assign frame_end  = load_next >= cc;

  lvbs_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && frame_end),
    .dividend_i (sum_next),
    .divisor_i  (cc),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // volume memory, read at the channel just read from the order memory
  lvbs_ram #(
    .WIDTH (VOL_W),
    .DEPTH (2 ** IDX_W)
  ) u_vol_ram (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_cnt_q[IDX_W-1:0]),
    .wdata_i (in_vol),
    .raddr_i (ord_rdata),
    .rdata_o (vol_rdata)
  );

  lvbs_order_store #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_order (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // sort key: thresholded volume, zero for channels beyond the count
  always_comb begin
    key_ch = (state_q == ST_OUT_W2) ? x_q : y_q;
    if ((CNT_W'(key_ch) < cc) &&
        ((avg_q == '0) || (SUM_W'(vol_rdata) >= avg_q))) begin
      key = vol_rdata;
    end else begin
      key = '0;
    end
    tsum = {1'b0, total_q} + {1'b0, key};
    trim = budget - total_q;
    jm1  = j_q - CNT_W'(1);
  end

  // order memory access
  always_comb begin
    ord_raddr = {side_q, i_q[IDX_W-1:0]};
    ord_we    = 1'b0;
    ord_waddr = {side_q, j_q[IDX_W-1:0]};
    ord_wdata = x_q;
    unique case (state_q)
      ST_IN_RD: begin
        ord_raddr = {side_q, jm1[IDX_W-1:0]};
        ord_we    = (j_q == '0);
      end
      ST_IN_W2: begin
        ord_we    = 1'b1;
        ord_wdata = (key < xkey_q) ? y_q : x_q;
      end
      ST_EM_RD: begin
        ord_raddr = {side_q, k_q[IDX_W-1:0]};
      end
      default: begin
        ord_we = 1'b0;
      end
    endcase
  end

  // sequencer with configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      cfg_count_q  <= CHANNEL_COUNT_RST;
      cfg_limit_q  <= MIX_LIMIT_RST;
      cfg_budget_q <= VOLUME_BUDGET_RST;
      load_cnt_q   <= '0;
      sum_q        <= '0;
      side_q       <= 1'b0;
      avg_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      n_q          <= '0;
      x_q          <= '0;
      y_q          <= '0;
      xkey_q       <= '0;
      total_q      <= '0;
      last_vol_q   <= '0;
      pend_vol_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_CHANNEL_COUNT: cfg_count_q  <= cfg_data_i[CFG_COUNT_W-1:0];
          CFG_MIX_LIMIT:     cfg_limit_q  <= cfg_data_i[CFG_LIMIT_W-1:0];
          CFG_VOLUME_BUDGET: cfg_budget_q <= cfg_data_i[CFG_BUDGET_W-1:0];
          default:           cfg_count_q  <= cfg_count_q;
        endcase
      end

      // result word taken
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        // volume loading
        ST_LOAD: begin
          if (in_fire) begin
            if (frame_end) begin
              load_cnt_q <= '0;
              sum_q      <= '0;
              side_q     <= in_data_i.side;
              state_q    <= ST_DIV;
            end else begin
              load_cnt_q <= load_next;
              sum_q      <= sum_next;
            end
          end
        end
        // average
        ST_DIV: begin
          if (div_done) begin
            avg_q   <= div_quo;
            i_q     <= CNT_W'(1);
            state_q <= ST_OUT_RD;
          end
        end
        // insertion sort, outer pass picks the entry to insert
        ST_OUT_RD: begin
          if (i_q >= cc) begin
            i_q     <= '0;
            n_q     <= '0;
            total_q <= '0;
            state_q <= ST_SEL_RD;
          end else begin
            state_q <= ST_OUT_W1;
          end
        end
        ST_OUT_W1: begin
          x_q     <= ord_rdata;
          state_q <= ST_OUT_W2;
        end
        ST_OUT_W2: begin
          xkey_q  <= key;
          j_q     <= i_q;
          state_q <= ST_IN_RD;
        end
        // inner pass shifts quieter entries up
        ST_IN_RD: begin
          if (j_q == '0) begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ST_OUT_RD;
          end else begin
            state_q <= ST_IN_W1;
          end
        end
        ST_IN_W1: begin
          y_q     <= ord_rdata;
          state_q <= ST_IN_W2;
        end
        ST_IN_W2: begin
          if (key < xkey_q) begin
            j_q     <= jm1;
            state_q <= ST_IN_RD;
          end else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ST_OUT_RD;
          end
        end
        // selection, loudest first
        ST_SEL_RD: begin
          state_q <= (i_q >= lim) ? ST_SEL_END : ST_SEL_W1;
        end
        ST_SEL_W1: begin
          y_q     <= ord_rdata;
          state_q <= ST_SEL_W2;
        end
        ST_SEL_W2: begin
          if (key == '0) begin
            state_q <= ST_SEL_END;
          end else if (tsum >= {1'b0, budget}) begin
            if (trim != '0) begin
              n_q        <= n_q + CNT_W'(1);
              last_vol_q <= trim;
            end
            state_q <= ST_SEL_END;
          end else begin
            total_q    <= tsum[VOL_W-1:0];
            n_q        <= n_q + CNT_W'(1);
            i_q        <= i_q + CNT_W'(1);
            last_vol_q <= key;
            state_q    <= ST_SEL_RD;
          end
        end
        ST_SEL_END: begin
          if (n_q == '0) begin
            state_q <= ST_EM_NONE;
          end else begin
            k_q     <= n_q - CNT_W'(1);
            state_q <= ST_EM_RD;
          end
        end
        // emission, quietest first
        ST_EM_RD: begin
          state_q <= ST_EM_W1;
        end
        ST_EM_W1: begin
          y_q     <= ord_rdata;
          state_q <= ST_EM_W2;
        end
        ST_EM_W2: begin
          pend_vol_q <= (k_q == n_q - CNT_W'(1)) ? last_vol_q : key;
          state_q    <= ST_EM_PUSH;
        end
        ST_EM_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.channel       <= ch_ext[OUT_CHANNEL_W-1:0];
            out_q.mix_volume    <= pend_ext[OUT_VOLUME_W-1:0];
            out_q.none_selected <= 1'b0;
            out_q.last          <= (k_q == '0);
            if (k_q == '0) begin
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q - CNT_W'(1);
              state_q <= ST_EM_RD;
            end
          end
        end
        ST_EM_NONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.channel       <= '0;
            out_q.mix_volume    <= '0;
            out_q.none_selected <= 1'b1;
            out_q.last          <= 1'b1;
            state_q             <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an empty frame word always closes the frame
  a_none_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.none_selected |-> out_data_o.last)
    else $error("empty selection word without last");

  // the average only arrives while waiting for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the average step");

  // the insertion point never passes the entry being inserted
  a_insert_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IN_RD |-> j_q <= i_q)
    else $error("insertion index beyond outer index");

  // every voice walked before the stop has been taken
  a_select_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEL_RD |-> n_q == i_q)
    else $error("selected voice count out of step with walk");

  // no volume word taken while the average is being formed
  a_load_vs_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("loading while divider busy");

endmodule

// ===== design/lvbs_ram.sv =====
// generic simple dual port ram with registered read
module lvbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lvbs_order_store.sv =====
// per side channel order memory, reading as identity until an entry is written
module lvbs_order_store
  import lvbs_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = LVBS_MAX_CHANNELS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [$clog2(MAX_CHANNELS):0]   waddr_i,
  input  logic [$clog2(MAX_CHANNELS)-1:0] wdata_i,
  input  logic [$clog2(MAX_CHANNELS):0]   raddr_i,
  output logic [$clog2(MAX_CHANNELS)-1:0] rdata_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CHANNELS);
  localparam int unsigned AW    = IDX_W + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  logic [DEPTH-1:0] valid_q;
  logic             rvalid_q;
  logic [AW-1:0]    raddr_q;
  logic [IDX_W-1:0] ram_rdata;

  lvbs_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // written marks, cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  // read address kept alongside the ram read
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_i;
  end

  // unwritten entry holds its own position
  assign rdata_o = rvalid_q ? ram_rdata : raddr_q[IDX_W-1:0];

endmodule

// ===== design/lvbs_div.sv =====
// restoring divider, one quotient bit per cycle
module lvbs_div #(
  parameter int unsigned DIVIDEND_W = 14,
  parameter int unsigned DIVISOR_W  = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

  logic [CW-1:0]         cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  ge;

  // one shift and trial subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= CW'(DIVIDEND_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
        rem_q <= rem_sub[DIVISOR_W-1:0];
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== test/tb_loudest_voice_budget_selector.sv =====
// self-checking testbench of the loudest voice budget selector
module tb_loudest_voice_budget_selector;
  import lvbs_pkg::*;

  localparam int unsigned NUM_CH        = LVBS_MAX_CHANNELS;
  localparam int unsigned RANDOM_WORDS  = 210;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_REPORTS   = 100;

  // volume patterns of a random frame
  typedef enum int unsigned {VOL_UNIFORM, VOL_SPARSE, VOL_TIED, VOL_QUIET} vol_style_e;

  // predicts the granted voices of each frame and checks them in arrival order
  class voice_grant_board;
    int unsigned count_reg, limit_reg, budget_reg;
    int unsigned frame_vols[NUM_CH];
    int unsigned chan_order[2][NUM_CH];
    int unsigned loaded, vol_sum;
    lvbs_out_t   pending_grants[$];
    int unsigned errors, words, frames, empty_frames, grants_seen;

    function new();
      count_reg  = CHANNEL_COUNT_RST;
      limit_reg  = MIX_LIMIT_RST;
      budget_reg = VOLUME_BUDGET_RST;
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < NUM_CH; i++) begin
          chan_order[s][i] = i;
          frame_vols[i]    = 0;
        end
      end
      loaded  = 0;
      vol_sum = 0;
      errors  = 0;
      words   = 0;
      frames  = 0;
      empty_frames = 0;
      grants_seen  = 0;
    endfunction

    // channel count as the block uses it: zero acts as one, large values saturate
    function int unsigned active_channels();
      if (count_reg == 0) return 1;
      if (count_reg > NUM_CH) return NUM_CH;
      return count_reg;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHANNEL_COUNT: count_reg  = data[CFG_COUNT_W-1:0];
        CFG_MIX_LIMIT:     limit_reg  = data[CFG_LIMIT_W-1:0];
        CFG_VOLUME_BUDGET: budget_reg = data[CFG_BUDGET_W-1:0];
        default: ;
      endcase
    endfunction

    function void load_volume(lvbs_in_t w);
      int unsigned cc, avg, lim, total, n, side, j, c, t;
      int unsigned work[NUM_CH];
      lvbs_out_t   g;
      cc = active_channels();
      words++;
      if (loaded < NUM_CH) frame_vols[loaded] = w.volume;
      vol_sum += w.volume;
      loaded++;
      if (loaded < cc) return;

      // frame complete: the closing word picks the side
      side = w.side;
      for (int i = 0; i < NUM_CH; i++) work[i] = (i < cc) ? frame_vols[i] : 0;
      avg     = vol_sum / cc;
      loaded  = 0;
      vol_sum = 0;

      // voices under a nonzero average drop out
      if (avg != 0) begin
        for (int i = 0; i < cc; i++) if (work[i] < avg) work[i] = 0;
      end

      // stable descending sort of the side's order, ties keep the previous order
      for (int i = 1; i < cc; i++) begin
        j = i;
        while (j > 0 && work[chan_order[side][j-1]] < work[chan_order[side][j]]) begin
          t = chan_order[side][j];
          chan_order[side][j]   = chan_order[side][j-1];
          chan_order[side][j-1] = t;
          j--;
        end
      end

      // loudest first until the limit or the budget, last voice trimmed to fit
      lim   = (limit_reg > cc) ? cc : limit_reg;
      n     = 0;
      total = 0;
      for (int i = 0; i < lim; i++) begin
        c = chan_order[side][i];
        if (work[c] == 0) break;
        if (total + work[c] >= budget_reg) begin
          work[c] = budget_reg - total;
          if (work[c] != 0) n++;
          break;
        end
        total += work[c];
        n++;
      end

      frames++;
      if (n == 0) begin
        g.channel       = '0;
        g.mix_volume    = '0;
        g.none_selected = 1'b1;
        g.last          = 1'b1;
        pending_grants.push_back(g);
        empty_frames++;
        return;
      end
      // granted voices leave quietest first
      for (int k = 0; k < n; k++) begin
        c = chan_order[side][n-1-k];
        g.channel       = c[OUT_CHANNEL_W-1:0];
        g.mix_volume    = work[c][OUT_VOLUME_W-1:0];
        g.none_selected = 1'b0;
        g.last          = (k == n - 1);
        pending_grants.push_back(g);
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_grant(lvbs_out_t got);
      lvbs_out_t want;
      grants_seen++;
      if (pending_grants.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("unexpected result word: channel %0d, mix_volume %0d, none_selected %0d",
                 got.channel, got.mix_volume, got.none_selected);
        return;
      end
      want = pending_grants.pop_front();
      compare_field("channel", want.channel, got.channel);
      compare_field("mix_volume", want.mix_volume, got.mix_volume);
      compare_field("none_selected", want.none_selected, got.none_selected);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  lvbs_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  lvbs_out_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  voice_grant_board sb = new();
  int unsigned      burst_left;
  int unsigned      random_words;
  int unsigned      settings_used;

  loudest_voice_budget_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock, period of two
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // note accepted volume words and check granted voice words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.load_volume(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_grant(out_data_o);
    end
  end

  // receiver: stall pattern switches between calm, choppy and long holds
  initial begin
    int unsigned stall_left, mode_left, mode;
    out_ready_i = 1'b0;
    stall_left  = 0;
    mode_left   = 0;
    mode        = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        case (mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 20);
          3: if ($urandom_range(0, 1) == 0) stall_left = 1;
          default: ;
        endcase
      end
    end
  end

  // one volume word, with a random gap at the start of each burst
  task automatic push_word(input lvbs_in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // directed frame: first volume in the top byte
  task automatic send_frame(input logic side, input logic [31:0] vols);
    lvbs_in_t w;
    for (int i = 0; i < sb.active_channels(); i++) begin
      w.side   = side;
      w.volume = vols[31-8*i -: 8];
      push_word(w);
    end
  endtask

  task automatic send_random_frame(input int unsigned len);
    vol_style_e style;
    lvbs_in_t   w;
    style = vol_style_e'($urandom_range(0, 3));
    for (int i = 0; i < len; i++) begin
      w.side = 1'($urandom_range(0, 1));
      case (style)
        VOL_UNIFORM: w.volume = 8'($urandom_range(0, 255));
        VOL_SPARSE:  w.volume = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        VOL_TIED: begin
          case ($urandom_range(0, 3))
            0:       w.volume = 8'd0;
            1:       w.volume = 8'd64;
            2:       w.volume = 8'd128;
            default: w.volume = 8'd255;
          endcase
        end
        default:     w.volume = 8'($urandom_range(0, 15));
      endcase
      push_word(w);
    end
    random_words += len;
  endtask

  // drop valid and wait for every predicted word plus a quiet spell
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_grants.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_register(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned cc, input int unsigned lim,
                                input int unsigned bud);
    settle();
    write_reg(CFG_CHANNEL_COUNT, 8'(cc));
    write_reg(CFG_MIX_LIMIT, 8'(lim));
    write_reg(CFG_VOLUME_BUDGET, 8'(bud));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // main sequence
  initial begin
    int unsigned phase, frames_here, len, cc, lim, bud, pick;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    burst_left    = 0;
    random_words  = 0;
    settings_used = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single channel frames: a count of zero acts as one
    apply_settings(0, 63, 255);
    send_frame(1'b0, {8'd255, 24'd0});
    send_frame(1'b1, {8'd0, 24'd0});
    send_frame(1'b0, {8'd1, 24'd0});
    // zero mix limit, then zero budget
    apply_settings(2, 0, 255);
    send_frame(1'b1, {8'd200, 8'd100, 16'd0});
    apply_settings(2, 2, 0);
    send_frame(1'b0, {8'd50, 8'd60, 16'd0});
    // two tied loud voices, a quiet one under the average, trimmed grant, silent frame
    apply_settings(3, 63, 100);
    send_frame(1'b1, {8'd90, 8'd90, 8'd30, 8'd0});
    send_frame(1'b0, 32'd0);
    // full scale volumes, then a stored order deciding a four way tie
    apply_settings(4, 4, 255);
    send_frame(1'b0, {4{8'd255}});
    send_frame(1'b1, {8'd10, 8'd20, 8'd30, 8'd40});
    send_frame(1'b1, {4{8'd50}});

    // random phases of whole frames, mostly small channel counts
    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      case (phase)
        0: begin
          cc  = 32;
          lim = 1;
          bud = 1;
        end
        1: begin
          cc  = 63;
          lim = 63;
          bud = 255;
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6) cc = $urandom_range(2, 8);
          else if (pick == 6) cc = $urandom_range(9, 31);
          else if (pick == 7) cc = $urandom_range(0, 1);
          else if (pick == 8) cc = 32;
          else cc = $urandom_range(33, 63);
          pick = $urandom_range(0, 9);
          if (pick == 0) lim = 0;
          else if (pick == 1) lim = $urandom_range(32, 63);
          else lim = $urandom_range(1, 8);
          pick = $urandom_range(0, 9);
          if (pick == 0) bud = 0;
          else if (pick == 1) bud = 255;
          else if (pick == 2) bud = $urandom_range(1, 16);
          else bud = $urandom_range(1, 255);
        end
      endcase
      apply_settings(cc, lim, bud);
      len = sb.active_channels();
      frames_here = (len >= 16) ? 1 : $urandom_range(1, 32 / len + 1);
      repeat (frames_here) send_random_frame(len);
      phase++;
    end

    settle();
    repeat (64) @(posedge clk_i);
    if (sb.pending_grants.size() != 0)
      $error("%0d predicted result words never arrived", sb.pending_grants.size());
    $display("covered %0d volume words in %0d frames over %0d register settings",
             sb.words, sb.frames, settings_used);
    $display("checked %0d result words, %0d frames with no voice selected",
             sb.grants_seen, sb.empty_frames);
    if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #600000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== loudest_voice_budget_selector.f =====
design/lvbs_pkg.sv
design/lvbs_ram.sv
design/lvbs_order_store.sv
design/lvbs_div.sv
design/loudest_voice_budget_selector.sv
test/tb_loudest_voice_budget_selector.sv
